### design/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; included by file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold cons whenever ante holds, outside reset.
`define ASSERT_IMPLIES(label, c, r, ante, cons, msg) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) else $error(msg);

// Hold cons in the cycle after ante, outside reset.
`define ASSERT_NEXT(label, c, r, ante, cons, msg) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) else $error(msg);

// Hold cond at every edge, reset included.
`define ASSERT_ALWAYS(label, c, cond, msg) \
    label: assert property (@(posedge c) (cond)) else $error(msg);

`endif

### design/rmmn_pkg.sv
// Types and constants of the min/max normalize unit.
// Depends on nothing; imported by every module of the unit but rmmn_fifo.
`timescale 1ns / 1ps

package rmmn_pkg;

    localparam int NUM_CH     = 3;
    localparam int PIX_W      = 8;
    localparam int PIX_FLOOR  = 0;
    localparam int PIX_CEIL   = 255;
    localparam int DIFF_W     = PIX_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int MAG_W      = PROD_W - 1;
    localparam int RADIX_BITS = 6;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_W      = RADIX_BITS * DIV_STEPS;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int SUM_W      = MAG_W + 2;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TMIN_RED   = 3'd0,
        REG_TMAX_RED   = 3'd1,
        REG_TMIN_GREEN = 3'd2,
        REG_TMAX_GREEN = 3'd3,
        REG_TMIN_BLUE  = 3'd4,
        REG_TMAX_BLUE  = 3'd5
    } reg_idx_t;

    typedef logic [NUM_CH-1:0][PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic             neg;
        logic             flat;
        logic [MAG_W-1:0] mag;
        logic [PIX_W-1:0] dvsr;
        logic [PIX_W-1:0] tmin;
    } op_t;

    typedef op_t [NUM_CH-1:0] work_t;

    typedef struct packed {
        logic load;
        logic step;
    } lane_ctl_t;

endpackage

### design/rgb_min_max_normalize_unit.sv
// Per-channel min/max contrast stretch. Measure words take one cycle each while the
// operand queue is not full; the channel lanes divide one normalize word at a time and
// load the next one in the same cycle the last result is pushed to the result queue.
// Reset (async, active low) sets min to 255, max to 0, targets to 0/255, queues empty.
// Depends on rmmn_pkg, rmmn_fifo, rmmn_front, rmmn_back.
`timescale 1ns / 1ps

module rgb_min_max_normalize_unit #(
    parameter int OP_DEPTH  = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rmmn_pkg::REG_IDX_W-1:0] cfg_addr,
    input  logic [rmmn_pkg::PIX_W-1:0]     cfg_wdata,
    input  logic                           push,
    output logic                           full,
    input  logic                           func,
    input  logic                           first_pixel,
    input  logic [rmmn_pkg::PIX_W-1:0]     red_in,
    input  logic [rmmn_pkg::PIX_W-1:0]     green_in,
    input  logic [rmmn_pkg::PIX_W-1:0]     blue_in,
    output logic                           empty,
    input  logic                           pop,
    output logic [rmmn_pkg::PIX_W-1:0]     red_out,
    output logic [rmmn_pkg::PIX_W-1:0]     green_out,
    output logic [rmmn_pkg::PIX_W-1:0]     blue_out
);

    import rmmn_pkg::*;

    pixel_t pix_in;
    pixel_t res_word;
    pixel_t res_rd;
    work_t  op_wr;
    work_t  op_rd;
    logic   op_push, op_pop, op_empty;
    logic   res_push, res_full;

    assign pix_in = {blue_in, green_in, red_in};

    rmmn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .push        (push),
        .op_full     (full),
        .func        (func),
        .first_pixel (first_pixel),
        .pix         (pix_in),
        .op_push     (op_push),
        .op_word     (op_wr)
    );

    rmmn_fifo #(
        .WIDTH ($bits(work_t)),
        .DEPTH (OP_DEPTH)
    ) u_op_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (op_push),
        .wr_data (op_wr),
        .full    (full),
        .rd_en   (op_pop),
        .rd_data (op_rd),
        .empty   (op_empty)
    );

    rmmn_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_empty (op_empty),
        .op_word  (op_rd),
        .op_pop   (op_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_word (res_word)
    );

    rmmn_fifo #(
        .WIDTH ($bits(pixel_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_word),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign red_out   = res_rd[0];
    assign green_out = res_rd[1];
    assign blue_out  = res_rd[2];

endmodule

### design/rmmn_fifo.sv
// Small register queue with show-ahead read, used between the unit's parts.
// Depends on nothing.
`timescale 1ns / 1ps

module rmmn_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

### design/rmmn_front.sv
// Front part: takes pixel words, tracks per-channel min/max, holds target registers,
// and builds divide operands for normalize words. Depends on rmmn_pkg.
`timescale 1ns / 1ps

module rmmn_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rmmn_pkg::REG_IDX_W-1:0] cfg_addr,
    input  logic [rmmn_pkg::PIX_W-1:0]     cfg_wdata,
    input  logic                           push,
    input  logic                           op_full,
    input  logic                           func,
    input  logic                           first_pixel,
    input  rmmn_pkg::pixel_t               pix,
    output logic                           op_push,
    output rmmn_pkg::work_t                op_word
);

    import rmmn_pkg::*;

    pixel_t max_reg, max_next;
    pixel_t min_reg, min_next;
    pixel_t tmin_reg, tmin_next;
    pixel_t tmax_reg, tmax_next;
    logic   accept;

    assign accept  = push && !op_full;
    assign op_push = accept && func;

    always_comb
    begin
        max_next  = max_reg;
        min_next  = min_reg;
        tmin_next = tmin_reg;
        tmax_next = tmax_reg;
        if (accept && !func)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                if (first_pixel)
                begin
                    max_next[c] = pix[c];
                    min_next[c] = pix[c];
                end
                else
                begin
                    if (pix[c] > max_reg[c])
                    begin
                        max_next[c] = pix[c];
                    end
                    if (pix[c] < min_reg[c])
                    begin
                        min_next[c] = pix[c];
                    end
                end
            end
        end
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_TMIN_RED:   tmin_next[0] = cfg_wdata;
                REG_TMAX_RED:   tmax_next[0] = cfg_wdata;
                REG_TMIN_GREEN: tmin_next[1] = cfg_wdata;
                REG_TMAX_GREEN: tmax_next[1] = cfg_wdata;
                REG_TMIN_BLUE:  tmin_next[2] = cfg_wdata;
                REG_TMAX_BLUE:  tmax_next[2] = cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                max_reg[c]  <= PIX_W'(PIX_FLOOR);
                min_reg[c]  <= PIX_W'(PIX_CEIL);
                tmin_reg[c] <= PIX_W'(PIX_FLOOR);
                tmax_reg[c] <= PIX_W'(PIX_CEIL);
            end
        end
        else
        begin
            max_reg  <= max_next;
            min_reg  <= min_next;
            tmin_reg <= tmin_next;
            tmax_reg <= tmax_next;
        end
    end

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_ch
        logic signed [DIFF_W-1:0] diff;
        logic signed [DIFF_W-1:0] span;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] prod_abs;

        assign diff     = $signed({1'b0, pix[c]}) - $signed({1'b0, min_reg[c]});
        assign span     = $signed({1'b0, tmax_reg[c]}) - $signed({1'b0, tmin_reg[c]});
        assign prod     = diff * span;
        assign prod_abs = prod[PROD_W-1] ? -prod : prod;

        assign op_word[c].neg  = prod[PROD_W-1];
        assign op_word[c].flat = (max_reg[c] <= min_reg[c]);
        assign op_word[c].mag  = prod_abs[MAG_W-1:0];
        assign op_word[c].dvsr = max_reg[c] - min_reg[c];
        assign op_word[c].tmin = tmin_reg[c];
    end

endmodule

### design/rmmn_lane.sv
// One channel lane: multi-bit-per-cycle restoring divide, sign, offset and saturate,
// or the target minimum when the span is flat. Depends on rmmn_pkg.
`timescale 1ns / 1ps

module rmmn_lane (
    input  logic                       clk,
    input  rmmn_pkg::lane_ctl_t        ctl,
    input  rmmn_pkg::op_t              op,
    output logic [rmmn_pkg::PIX_W-1:0] result
);

    import rmmn_pkg::*;

    logic [DIV_W-1:0] q_reg, q_next;
    logic [PIX_W:0]   r_reg, r_next;
    logic [PIX_W-1:0] d_reg;
    logic [PIX_W-1:0] tmin_reg;
    logic             neg_reg;
    logic             flat_reg;
    logic [SUM_W-1:0] mag_ext;
    logic [SUM_W-1:0] sq;
    logic [SUM_W-1:0] sum;

    always_comb
    begin
        logic [PIX_W:0] t;
        q_next = q_reg;
        r_next = r_reg;
        for (int i = 0; i < RADIX_BITS; i++)
        begin
            t      = {r_next[PIX_W-1:0], q_next[DIV_W-1]};
            q_next = {q_next[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, d_reg})
            begin
                r_next    = t - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            else
            begin
                r_next = t;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            q_reg    <= {{(DIV_W - MAG_W){1'b0}}, op.mag};
            r_reg    <= '0;
            d_reg    <= op.dvsr;
            tmin_reg <= op.tmin;
            neg_reg  <= op.neg;
            flat_reg <= op.flat;
        end
        else if (ctl.step)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign mag_ext = {{(SUM_W - MAG_W){1'b0}}, q_reg[MAG_W-1:0]};
    assign sq      = neg_reg ? (~mag_ext + 1'b1) : mag_ext;
    assign sum     = sq + {{(SUM_W - PIX_W){1'b0}}, tmin_reg};

    always_comb
    begin
        priority if (flat_reg)
        begin
            result = tmin_reg;
        end
        else if (sum[SUM_W-1])
        begin
            result = PIX_W'(PIX_FLOOR);
        end
        else if (|sum[SUM_W-2:PIX_W])
        begin
            result = PIX_W'(PIX_CEIL);
        end
        else
        begin
            result = sum[PIX_W-1:0];
        end
    end

endmodule

### design/rmmn_back.sv
// Back part: sequencer that pops operand words, runs the three channel lanes,
// and pushes finished pixels. Depends on rmmn_pkg and rmmn_lane.
`timescale 1ns / 1ps

module rmmn_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_empty,
    input  rmmn_pkg::work_t  op_word,
    output logic             op_pop,
    input  logic             res_full,
    output logic             res_push,
    output rmmn_pkg::pixel_t res_word
);

    import rmmn_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_PUSH = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    lane_ctl_t       ctl;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_pop     = 1'b0;
        res_push   = 1'b0;
        ctl.load   = 1'b0;
        ctl.step   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!op_empty)
                begin
                    op_pop     = 1'b1;
                    ctl.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                ctl.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (!op_empty)
                    begin
                        op_pop     = 1'b1;
                        ctl.load   = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        rmmn_lane u_lane (
            .clk    (clk),
            .ctl    (ctl),
            .op     (op_word[c]),
            .result (res_word[c])
        );
    end

endmodule

### design/rmmn_checker.sv
// Port-level checker for the normalize unit, bound to the top level.
// Depends on rmmn_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rmmn_checker #(
    parameter int CAP = 5
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           push,
    input logic                           full,
    input logic                           func,
    input logic                           empty,
    input logic                           pop,
    input logic [rmmn_pkg::PIX_W-1:0]     red_out,
    input logic [rmmn_pkg::PIX_W-1:0]     green_out,
    input logic [rmmn_pkg::PIX_W-1:0]     blue_out
);

    localparam int PEND_W = $clog2(CAP + 2);

    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              in_norm, out_take;

    assign in_norm  = push && !full && func;
    assign out_take = pop && !empty;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_norm && !out_take)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (out_take && !in_norm)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `ASSERT_ALWAYS(a_reset_empty, clk, rst_n || empty, "results present during reset")
    `ASSERT_IMPLIES(a_no_phantom, clk, rst_n, !empty, pend_reg != '0, "result without normalize word")
    `ASSERT_IMPLIES(a_bounded, clk, rst_n, 1'b1, pend_reg <= PEND_W'(CAP), "more words in flight than storage")
    `ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(red_out) && $stable(green_out) && $stable(blue_out), "waiting result changed")

endmodule

bind rgb_min_max_normalize_unit rmmn_checker #(
    .CAP (OP_DEPTH + RES_DEPTH + 1)
) u_rmmn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .func      (func),
    .empty     (empty),
    .pop       (pop),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
);

### dv/rgb_min_max_normalize_unit_tb.sv
// Testbench for rgb_min_max_normalize_unit: directed table, then random images per target setting.
// Every normalize word is checked against a typed value or an in-bench contrast-stretch predictor.
// Depends on rmmn_pkg and rgb_min_max_normalize_unit.
`timescale 1ns / 1ps

module rgb_min_max_normalize_unit_tb;

    import rmmn_pkg::*;

    localparam logic FUNC_MEASURE   = 1'b0;
    localparam logic FUNC_NORMALIZE = 1'b1;

    localparam logic [REG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int NUM_REGS        = 6;
    localparam int DIR_ROWS        = 19;
    localparam int NUM_PHASES      = 10;
    localparam int WORDS_PER_PHASE = 114;
    localparam int HOLD_PHASE      = 2;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 24;
    localparam int CYCLE_LIMIT     = 400000;

    localparam int POP_ALWAYS = 0;
    localparam int POP_COIN   = 1;
    localparam int POP_EVERY4 = 2;
    localparam int POP_RARE   = 3;

    typedef struct packed {
        logic   op;
        logic   first;
        pixel_t px;
    } pix_word_t;

    typedef struct packed {
        pix_word_t w;
        logic      typed;
        pixel_t    want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [REG_IDX_W-1:0] cfg_addr;
    logic [PIX_W-1:0] cfg_wdata;
    logic push;
    logic full;
    logic func;
    logic first_pixel;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic empty;
    logic pop = 1'b0;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;

    logic [PIX_W-1:0] target [NUM_REGS];
    logic [PIX_W-1:0] seen_max [NUM_CH];
    logic [PIX_W-1:0] seen_min [NUM_CH];
    pixel_t stretched_q [$];

    row_t dir_rows [DIR_ROWS];
    int error_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int pop_mode = POP_ALWAYS;
    int pop_tick = 0;

    rgb_min_max_normalize_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .push        (push),
        .full        (full),
        .func        (func),
        .first_pixel (first_pixel),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .empty       (empty),
        .pop         (pop),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic pixel_t rgb(input int r, input int g, input int b);
        pixel_t p;
        p[0] = r[PIX_W-1:0];
        p[1] = g[PIX_W-1:0];
        p[2] = b[PIX_W-1:0];
        return p;
    endfunction

    function automatic logic [PIX_W-1:0] scale_channel(input int p, input int lo, input int hi,
                                                      input int tlo, input int thi);
        int v;
        if (hi <= lo)
        begin
            v = tlo;
        end
        else
        begin
            v = ((p - lo) * (thi - tlo)) / (hi - lo) + tlo;
        end
        if (v < PIX_FLOOR)
            v = PIX_FLOOR;
        if (v > PIX_CEIL)
            v = PIX_CEIL;
        return v[PIX_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] rand_chan();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 8'd0;
        else if (sel == 1)
            return 8'd255;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic pixel_t rand_pixel();
        return {rand_chan(), rand_chan(), rand_chan()};
    endfunction

    // Pick a pixel inside the measured span of each channel.
    function automatic pixel_t span_pixel();
        pixel_t p;
        for (int c = 0; c < NUM_CH; c++)
        begin
            p[c] = PIX_W'($urandom_range(int'(seen_min[c]), int'(seen_max[c])));
        end
        return p;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Apply one accepted word to the statistics; queue the expected pixel (typed or stretched) on normalize.
    task automatic track_word(input pix_word_t w, input logic typed, input pixel_t want);
        pixel_t res;
        if (w.op == FUNC_MEASURE)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                if (w.first)
                begin
                    seen_max[c] = w.px[c];
                    seen_min[c] = w.px[c];
                end
                else
                begin
                    if (w.px[c] > seen_max[c])
                        seen_max[c] = w.px[c];
                    if (w.px[c] < seen_min[c])
                        seen_min[c] = w.px[c];
                end
            end
        end
        else
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                res[c] = scale_channel(int'(w.px[c]), int'(seen_min[c]), int'(seen_max[c]),
                                       int'(target[2*c]), int'(target[2*c+1]));
            end
            stretched_q.push_back(typed ? want : res);
        end
    endtask

    task automatic send_word(input pix_word_t w, input logic typed, input pixel_t want);
        int gap;
        push        <= 1'b1;
        func        <= w.op;
        first_pixel <= w.first;
        red_in      <= w.px[0];
        green_in    <= w.px[1];
        blue_in     <= w.px[2];
        do
            @(posedge clk);
        while (full);
        track_word(w, typed, want);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Hold until every stretched pixel is out, then let trailing measure words finish.
    task automatic wait_drain();
        while (stretched_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_targets(input logic [NUM_REGS-1:0][PIX_W-1:0] vals);
        cfg_wr_en <= 1'b1;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_addr  <= reg_idx_t'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
            target[i] = vals[i];
        end
        cfg_addr  <= CFG_SPARE_LO;
        cfg_wdata <= PIX_W'($urandom_range(0, 255));
        @(posedge clk);
        cfg_addr  <= CFG_SPARE_HI;
        cfg_wdata <= PIX_W'($urandom_range(0, 255));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_word();
        pixel_t want;
        if (stretched_q.size() == 0)
        begin
            report_error($sformatf("unexpected word r=%0d g=%0d b=%0d",
                                   red_out, green_out, blue_out));
        end
        else
        begin
            want = stretched_q.pop_front();
            if (red_out !== want[0])
                report_error($sformatf("red got %0d want %0d", red_out, want[0]));
            if (green_out !== want[1])
                report_error($sformatf("green got %0d want %0d", green_out, want[1]));
            if (blue_out !== want[2])
                report_error($sformatf("blue got %0d want %0d", blue_out, want[2]));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                check_word();
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            pop_tick++;
            if (pop_tick % 50 == 0)
                pop_mode = $urandom_range(POP_ALWAYS, POP_RARE);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                case (pop_mode)
                    POP_ALWAYS: pop <= 1'b1;
                    POP_COIN:   pop <= 1'($urandom_range(0, 1));
                    POP_EVERY4: pop <= (pop_tick % 4 == 0);
                    default:    pop <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        logic [NUM_REGS-1:0][PIX_W-1:0] vals;
        pix_word_t w;
        int phase_words;
        int n_meas;
        int n_norm;

        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= REG_TMIN_RED;
        cfg_wdata   <= '0;
        push        <= 1'b0;
        func        <= FUNC_MEASURE;
        first_pixel <= 1'b0;
        red_in      <= '0;
        green_in    <= '0;
        blue_in     <= '0;
        for (int i = 0; i < NUM_REGS; i++)
            target[i] = (i % 2 == 0) ? 8'd0 : 8'd255;
        for (int c = 0; c < NUM_CH; c++)
        begin
            seen_max[c] = PIX_W'(PIX_FLOOR);
            seen_min[c] = PIX_W'(PIX_CEIL);
        end

        dir_rows[0]  = '{'{FUNC_NORMALIZE, 1'b0, rgb(128, 0, 255)}, 1'b1, rgb(0, 0, 0)};
        dir_rows[1]  = '{'{FUNC_NORMALIZE, 1'b1, rgb(255, 255, 255)}, 1'b1, rgb(0, 0, 0)};
        dir_rows[2]  = '{'{FUNC_MEASURE, 1'b1, rgb(0, 0, 0)}, 1'b0, rgb(0, 0, 0)};
        dir_rows[3]  = '{'{FUNC_NORMALIZE, 1'b0, rgb(77, 200, 3)}, 1'b1, rgb(0, 0, 0)};
        dir_rows[4]  = '{'{FUNC_MEASURE, 1'b0, rgb(255, 255, 255)}, 1'b0, rgb(0, 0, 0)};
        dir_rows[5]  = '{'{FUNC_NORMALIZE, 1'b0, rgb(0, 128, 255)}, 1'b1, rgb(0, 128, 255)};
        dir_rows[6]  = '{'{FUNC_NORMALIZE, 1'b1, rgb(255, 0, 1)}, 1'b1, rgb(255, 0, 1)};
        dir_rows[7]  = '{'{FUNC_MEASURE, 1'b1, rgb(100, 50, 200)}, 1'b0, rgb(0, 0, 0)};
        dir_rows[8]  = '{'{FUNC_MEASURE, 1'b0, rgb(150, 60, 201)}, 1'b0, rgb(0, 0, 0)};
        dir_rows[9]  = '{'{FUNC_NORMALIZE, 1'b0, rgb(0, 255, 199)}, 1'b1, rgb(0, 255, 0)};
        dir_rows[10] = '{'{FUNC_NORMALIZE, 1'b0, rgb(125, 55, 201)}, 1'b0, rgb(0, 0, 0)};
        dir_rows[11] = '{'{FUNC_NORMALIZE, 1'b0, rgb(150, 50, 200)}, 1'b0, rgb(0, 0, 0)};
        dir_rows[12] = '{'{FUNC_MEASURE, 1'b0, rgb(90, 61, 199)}, 1'b0, rgb(0, 0, 0)};
        dir_rows[13] = '{'{FUNC_NORMALIZE, 1'b0, rgb(95, 61, 255)}, 1'b0, rgb(0, 0, 0)};
        dir_rows[14] = '{'{FUNC_MEASURE, 1'b1, rgb(255, 0, 128)}, 1'b0, rgb(0, 0, 0)};
        dir_rows[15] = '{'{FUNC_NORMALIZE, 1'b0, rgb(255, 0, 128)}, 1'b1, rgb(0, 0, 0)};
        dir_rows[16] = '{'{FUNC_NORMALIZE, 1'b0, rgb(0, 255, 0)}, 1'b1, rgb(0, 0, 0)};
        dir_rows[17] = '{'{FUNC_MEASURE, 1'b0, rgb(0, 255, 0)}, 1'b0, rgb(0, 0, 0)};
        dir_rows[18] = '{'{FUNC_NORMALIZE, 1'b0, rgb(17, 240, 128)}, 1'b0, rgb(0, 0, 0)};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
        push <= 1'b0;
        wait_drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                case (ph)
                    0: vals[i] = (i % 2 == 0) ? 8'd255 : 8'd0;
                    1: vals[i] = 8'd0;
                    2: vals[i] = 8'd255;
                    3: vals[i] = (i % 2 == 0) ? 8'd0 : 8'd255;
                    4: vals[i] = (i < 2) ? ((i == 0) ? 8'd0 : 8'd255)
                               : (i < 4) ? ((i == 2) ? 8'd255 : 8'd0) : 8'd128;
                    default: vals[i] = rand_chan();
                endcase
            end
            program_targets(vals);
            if (ph == HOLD_PHASE)
                hold_req++;
            phase_words = 0;
            while (phase_words < WORDS_PER_PHASE)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    w.op    = 1'($urandom_range(0, 1));
                    w.first = 1'($urandom_range(0, 1));
                    w.px    = rand_pixel();
                    send_word(w, 1'b0, '0);
                    phase_words++;
                end
                else
                begin
                    n_meas = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
                    n_norm = $urandom_range(1, 12);
                    for (int i = 0; i < n_meas; i++)
                    begin
                        w.op    = FUNC_MEASURE;
                        w.first = (i == 0);
                        w.px    = rand_pixel();
                        send_word(w, 1'b0, '0);
                    end
                    for (int i = 0; i < n_norm; i++)
                    begin
                        w.op    = FUNC_NORMALIZE;
                        w.first = 1'($urandom_range(0, 1));
                        w.px    = ($urandom_range(0, 3) == 0) ? rand_pixel() : span_pixel();
                        send_word(w, 1'b0, '0);
                    end
                    phase_words += n_meas + n_norm;
                end
            end
            push <= 1'b0;
            wait_drain();
        end

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### rgb_min_max_normalize_unit.f
+incdir+design
design/rmmn_pkg.sv
design/rmmn_fifo.sv
design/rmmn_front.sv
design/rmmn_lane.sv
design/rmmn_back.sv
design/rgb_min_max_normalize_unit.sv
design/rmmn_checker.sv
dv/rgb_min_max_normalize_unit_tb.sv
